### hdl/zcbs_pkg.sv
package zcbs_pkg;

	localparam int SampleW = 16;
	localparam int IdxW = 12;
	localparam int CntW = 13;
	localparam int SumW = 14;
	localparam int SqW = 26;
	localparam int EnW = 44;
	localparam int MaxSamples = 4096;
	localparam logic [31:0] DbPerLog2Q30 = 32'd3232284966;

	localparam logic [1:0] RegRate = 2'd0;
	localparam logic [1:0] RegMinPer = 2'd1;
	localparam logic [1:0] RegMaxPer = 2'd2;

	typedef enum logic [3:0] {
		ST_RUN,
		ST_PREP,
		ST_MUL,
		ST_NUM,
		ST_DIVM,
		ST_SQRT,
		ST_DIVS,
		ST_NORM,
		ST_LOG,
		ST_DB,
		ST_OUT
	} zcbs_state_t;

	// controller to datapath
	typedef struct packed {
		logic acc_en;
		logic clear;
		logic prep;
		logic mul;
		logic num;
		logic divm_init;
		logic div_step;
		logic sqrt_init;
		logic sqrt_step;
		logic divs_init;
		logic norm_step;
		logic log_step;
		logic db;
		logic load_out;
	} zcbs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic norm_done;
		logic log_done;
	} zcbs_sts_t;

endpackage

### hdl/zcbs_in_if.sv
interface zcbs_in_if;
	logic valid;
	logic ready;
	logic signed [zcbs_pkg::SampleW-1:0] sample;
	logic last_sample;
	modport source(output valid, output sample, output last_sample, input ready);
	modport sink(input valid, input sample, input last_sample, output ready);
endinterface

### hdl/zcbs_out_if.sv
interface zcbs_out_if;
	logic valid;
	logic ready;
	logic [15:0] mean_period_q8;
	logic [15:0] period_spread_q8;
	logic signed [15:0] energy_db_q8;
	logic has_period;
	logic is_breathing;
	modport source(output valid, output mean_period_q8, output period_spread_q8,
		output energy_db_q8, output has_period, output is_breathing, input ready);
	modport sink(input valid, input mean_period_q8, input period_spread_q8,
		input energy_db_q8, input has_period, input is_breathing, output ready);
endinterface

### hdl/zcbs_cfg_if.sv
interface zcbs_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### hdl/zcbs_ctrl.sv
module zcbs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  logic out_busy,
	input  zcbs_pkg::zcbs_sts_t sts,
	output zcbs_pkg::zcbs_cmd_t cmd
);

	zcbs_pkg::zcbs_state_t state_q, state_nx;
	logic acc;

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zcbs_pkg::ST_RUN;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			zcbs_pkg::ST_RUN: if (acc && in_last) state_nx = zcbs_pkg::ST_PREP;
			zcbs_pkg::ST_PREP: state_nx = zcbs_pkg::ST_MUL;
			zcbs_pkg::ST_MUL: state_nx = zcbs_pkg::ST_NUM;
			zcbs_pkg::ST_NUM: state_nx = zcbs_pkg::ST_DIVM;
			zcbs_pkg::ST_DIVM: if (sts.div_done) state_nx = zcbs_pkg::ST_SQRT;
			zcbs_pkg::ST_SQRT: if (sts.sqrt_done) state_nx = zcbs_pkg::ST_DIVS;
			zcbs_pkg::ST_DIVS: if (sts.div_done) state_nx = zcbs_pkg::ST_NORM;
			zcbs_pkg::ST_NORM: if (sts.norm_done) state_nx = zcbs_pkg::ST_LOG;
			zcbs_pkg::ST_LOG: if (sts.log_done) state_nx = zcbs_pkg::ST_DB;
			zcbs_pkg::ST_DB: state_nx = zcbs_pkg::ST_OUT;
			zcbs_pkg::ST_OUT: if (!out_busy) state_nx = zcbs_pkg::ST_RUN;
			default: state_nx = zcbs_pkg::ST_RUN;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			zcbs_pkg::ST_RUN: begin
				in_ready = 1'b1;
				cmd.acc_en = acc;
			end
			zcbs_pkg::ST_PREP: cmd.prep = 1'b1;
			zcbs_pkg::ST_MUL: cmd.mul = 1'b1;
			zcbs_pkg::ST_NUM: begin
				cmd.num = 1'b1;
				cmd.divm_init = 1'b1;
			end
			zcbs_pkg::ST_DIVM: begin
				cmd.div_step = 1'b1;
				cmd.sqrt_init = sts.div_done;
			end
			zcbs_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cmd.divs_init = sts.sqrt_done;
			end
			zcbs_pkg::ST_DIVS: cmd.div_step = 1'b1;
			zcbs_pkg::ST_NORM: cmd.norm_step = 1'b1;
			zcbs_pkg::ST_LOG: cmd.log_step = 1'b1;
			zcbs_pkg::ST_DB: cmd.db = 1'b1;
			zcbs_pkg::ST_OUT: begin
				cmd.load_out = !out_busy;
				cmd.clear = !out_busy;
			end
			default: ;
		endcase
	end

endmodule

### hdl/zcbs_dp.sv
module zcbs_dp (
	input  logic clk,
	input  logic arst_n,
	input  zcbs_pkg::zcbs_cmd_t cmd,
	output zcbs_pkg::zcbs_sts_t sts,
	input  logic signed [zcbs_pkg::SampleW-1:0] sample,
	input  logic [15:0] rate_q8,
	input  logic [15:0] min_q8,
	input  logic [15:0] max_q8,
	output logic [15:0] mean_q8,
	output logic [15:0] spread_q8,
	output logic [15:0] db_q8,
	output logic has_per,
	output logic breath
);

	localparam int DW = 30;   // n*rate
	localparam int NumW = 40; // n*sq - s^2
	localparam int QW = 48;
	localparam int CntW = zcbs_pkg::CntW;
	localparam int SumW = zcbs_pkg::SumW;
	localparam int SqW = zcbs_pkg::SqW;

	// window accumulation state
	logic [zcbs_pkg::IdxW:0] idx_q;
	logic prev_neg_q, first_q, rise_seen_q, fall_seen_q;
	logic [zcbs_pkg::IdxW-1:0] rise_idx_q, fall_idx_q;
	logic [zcbs_pkg::CntW-1:0] cnt_q;
	logic [zcbs_pkg::SumW-1:0] sum_q;
	logic [zcbs_pkg::SqW-1:0] sq_q;
	logic [zcbs_pkg::EnW-1:0] en_q;

	logic neg, rise, fall, add_r, add_f, in_win;
	logic [zcbs_pkg::IdxW-1:0] t, dr, dfl;
	logic [zcbs_pkg::IdxW:0] d1, d2;
	logic [zcbs_pkg::CntW-1:0] cnt_nx;
	logic [zcbs_pkg::SumW:0] sum_nx;
	logic [zcbs_pkg::SqW:0] sq_nx;
	logic signed [31:0] smp_x;
	logic [31:0] sq_smp;

	assign t = idx_q[zcbs_pkg::IdxW-1:0];
	assign in_win = idx_q < (zcbs_pkg::IdxW+1)'(zcbs_pkg::MaxSamples);
	assign neg = sample[zcbs_pkg::SampleW-1];
	assign rise = first_q && prev_neg_q && !neg;
	assign fall = first_q && !prev_neg_q && neg;
	assign add_r = rise && rise_seen_q;
	assign add_f = fall && fall_seen_q;
	assign dr = t - rise_idx_q;
	assign dfl = t - fall_idx_q;
	assign d1 = add_r ? {1'b0, dr} : '0;
	assign d2 = add_f ? {1'b0, dfl} : '0;
	assign smp_x = 32'(sample);
	assign sq_smp = 32'(smp_x * smp_x);

	// pool intervals from one sample (only one crossing kind per sample)
	always_comb begin
		cnt_nx = cnt_q + CntW'(add_r) + CntW'(add_f);
		sum_nx = (SumW+1)'(sum_q) + (SumW+1)'(d1) + (SumW+1)'(d2);
		sq_nx = (SqW+1)'(sq_q) + (SqW+1)'(d1 * d1) + (SqW+1)'(d2 * d2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			prev_neg_q <= 1'b0;
			first_q <= 1'b0;
			rise_seen_q <= 1'b0;
			fall_seen_q <= 1'b0;
			rise_idx_q <= '0;
			fall_idx_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			en_q <= '0;
		end else if (cmd.clear) begin
			idx_q <= '0;
			prev_neg_q <= 1'b0;
			first_q <= 1'b0;
			rise_seen_q <= 1'b0;
			fall_seen_q <= 1'b0;
			rise_idx_q <= '0;
			fall_idx_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			en_q <= '0;
		end else if (cmd.acc_en && in_win) begin
			idx_q <= idx_q + 1'b1;
			prev_neg_q <= neg;
			first_q <= 1'b1;
			if (rise) begin
				rise_idx_q <= t;
				rise_seen_q <= 1'b1;
			end
			if (fall) begin
				fall_idx_q <= t;
				fall_seen_q <= 1'b1;
			end
			cnt_q <= cnt_nx;
			sum_q <= sum_nx[SumW-1:0];
			sq_q <= sq_nx[SqW-1:0];
			en_q <= en_q + zcbs_pkg::EnW'(sq_smp);
		end
	end

	// end-of-window arithmetic registers
	logic [15:0] rate_q;
	logic [DW-1:0] d_q;
	logic [27:0] ss_q;         // s*s
	logic [38:0] nsq_q;        // n*sq
	logic [NumW-1:0] num_q;
	logic [QW-1:0] quo_q;
	logic [5:0] dcnt_q;
	logic [51:0] sx_q;         // sqrt radicand
	logic [25:0] root_q;
	logic [53:0] srem_q;
	logic [4:0] scnt_q;
	logic [15:0] mean_q, spr_q;
	logic [zcbs_pkg::EnW-1:0] ev_q;
	logic [5:0] p_q;
	logic nstarted_q;

	// prepare: effective rate and first products, then n*rate and the numerator
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rate_q <= (rate_q8 == 16'd0) ? 16'd1 : rate_q8;
			ss_q <= 28'(sum_q * sum_q);
			nsq_q <= 39'(cnt_q * sq_q);
		end
		if (cmd.mul) begin
			d_q <= DW'(cnt_q * rate_q);
		end
		if (cmd.num) begin
			num_q <= NumW'(nsq_q) - NumW'(ss_q);
		end
	end

	// shared restoring divider: quo = floor(rem / (2d)) over QW steps
	logic [QW+DW:0] pr_q;
	always_ff @(posedge clk) begin
		if (cmd.divm_init) begin
			pr_q <= (QW+DW+1)'({sum_q, 17'd0}) + (QW+DW+1)'(d_q);
			dcnt_q <= 6'(QW);
			quo_q <= '0;
		end else if (cmd.divs_init) begin
			pr_q <= (QW+DW+1)'({root_q, 11'd0}) + (QW+DW+1)'(d_q);
			dcnt_q <= 6'(QW);
			quo_q <= '0;
		end else if (cmd.div_step && dcnt_q != 6'd0) begin
			if (pr_q[QW+DW:QW-1] >= (DW+2)'({d_q, 1'b0})) begin
				pr_q <= {pr_q[QW+DW-1:QW-1] - (DW+1)'({d_q, 1'b0}), pr_q[QW-2:0], 1'b0};
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				pr_q <= {pr_q[QW+DW-1:0], 1'b0};
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 1'b1;
		end
	end
	assign sts.div_done = (dcnt_q == 6'd0) && !cmd.divm_init && !cmd.divs_init;

	// mark the first normalize cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nstarted_q <= 1'b0;
		end else begin
			nstarted_q <= cmd.norm_step;
		end
	end

	// capture mean after the first divide, spread after the second
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) mean_q <= (|quo_q[QW-1:16]) ? 16'hFFFF : quo_q[15:0];
		if (cmd.norm_step && !nstarted_q)
			spr_q <= (|quo_q[QW-1:16]) ? 16'hFFFF : quo_q[15:0];
	end

	// bit-pair square root of num << 12
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sx_q <= {num_q, 12'd0};
			root_q <= '0;
			srem_q <= '0;
			scnt_q <= 5'd26;
		end else if (cmd.sqrt_step && scnt_q != 5'd0) begin
			if ({srem_q[51:0], sx_q[51:50]} >= {26'd0, root_q, 2'b01}) begin
				srem_q <= {srem_q[51:0], sx_q[51:50]} - {26'd0, root_q, 2'b01};
				root_q <= {root_q[24:0], 1'b1};
			end else begin
				srem_q <= {srem_q[51:0], sx_q[51:50]};
				root_q <= {root_q[24:0], 1'b0};
			end
			sx_q <= {sx_q[49:0], 2'b00};
			scnt_q <= scnt_q - 1'b1;
		end
	end
	assign sts.sqrt_done = (scnt_q == 5'd0) && !cmd.sqrt_init;

	// energy normalize: one bit per cycle to find the leading one
	always_ff @(posedge clk) begin
		if (cmd.norm_step && !nstarted_q) begin
			ev_q <= en_q;
			p_q <= 6'(zcbs_pkg::EnW - 1);
		end else if (cmd.norm_step && !ev_q[zcbs_pkg::EnW-1] && p_q != 6'd0) begin
			ev_q <= {ev_q[zcbs_pkg::EnW-2:0], 1'b0};
			p_q <= p_q - 1'b1;
		end
	end
	assign sts.norm_done = nstarted_q && (ev_q[zcbs_pkg::EnW-1] || p_q == 6'd0);

	// log2 fraction bits by repeated squaring
	logic [32:0] m_q;
	logic [15:0] lf_q;
	logic [4:0] lcnt_q;
	logic lstart_q;
	logic [65:0] msq;
	assign msq = 66'(m_q * m_q) >> 31;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lstart_q <= 1'b0;
		else lstart_q <= cmd.log_step;
	end
	always_ff @(posedge clk) begin
		if (cmd.log_step && !lstart_q) begin
			m_q <= 33'(ev_q[zcbs_pkg::EnW-1 -: 32]);
			lf_q <= '0;
			lcnt_q <= 5'd16;
		end else if (cmd.log_step && lcnt_q != 5'd0) begin
			if (msq[32]) begin
				m_q <= 33'(msq >> 1);
				lf_q <= {lf_q[14:0], 1'b1};
			end else begin
				m_q <= msq[32:0];
				lf_q <= {lf_q[14:0], 1'b0};
			end
			lcnt_q <= lcnt_q - 1'b1;
		end
	end
	assign sts.log_done = lstart_q && lcnt_q == 5'd0;

	// dB scaling
	logic [53:0] dbp_q;
	always_ff @(posedge clk) begin
		if (cmd.db) dbp_q <= 54'({p_q, lf_q} * zcbs_pkg::DbPerLog2Q30);
	end

	// breathing verdict inputs and outputs
	logic [31:0] s16;
	logic [47:0] mind, maxd;
	assign s16 = {2'b0, sum_q, 16'd0};
	always_ff @(posedge clk) begin
		if (cmd.num) begin
			mind <= 48'(min_q8 * d_q);
			maxd <= 48'(max_q8 * d_q);
		end
	end

	logic [37:0] dbr;
	assign dbr = 38'((dbp_q + 54'(64'd1 << 37)) >> 38);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			has_per <= cnt_q != '0;
			mean_q8 <= (cnt_q != '0) ? mean_q : 16'd0;
			spread_q8 <= (cnt_q != '0) ? spr_q : 16'd0;
			breath <= (cnt_q != '0) && (48'(s16) >= mind) && (48'(s16) <= maxd)
				&& ({num_q, 2'b00} <= 42'(ss_q));
			if (en_q == '0) db_q8 <= 16'h8000;
			else db_q8 <= (dbr > 38'd32767) ? 16'h7FFF : dbr[15:0];
		end
	end

endmodule

### hdl/zero_crossing_breath_stats.sv
// Zero-crossing breath statistics.
// Channels: in (sample, last_sample), out (one result per window) and cfg
// (index 0 sample rate, 1 minimum period, 2 maximum period, Q8.8).
// Samples are taken one per cycle while a window is open. After the
// transfer that carries last_sample, input ready drops and the window-end
// sequencer runs: the setup states PREP, MUL and NUM, a 48-step divider
// for the mean, a 26-step square root, a second 48-step divider for the
// spread, a leading-one search whose length depends on the energy, a
// 16-step log2 loop, the dB state and the output state. Input ready
// returns together with out valid.
// The result is held on out while the sink stalls; if the previous result
// is still waiting, the output state holds until it is transferred.
// Reset clears all window state and loads the default registers
// (20 Hz, 1 s, 6 s). Configuration is taken in any cycle.
module zero_crossing_breath_stats (
	input logic clk,
	input logic arst_n,
	zcbs_in_if.sink in,
	zcbs_out_if.source out,
	zcbs_cfg_if.sink cfg
);

	zcbs_pkg::zcbs_cmd_t cmd;
	zcbs_pkg::zcbs_sts_t sts;
	logic [15:0] rate_q, min_q, max_q;
	logic [15:0] mean, spread, db;
	logic hp, br, ovalid_q;

	assign cfg.ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 16'd5120;
			min_q <= 16'd256;
			max_q <= 16'd1536;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				zcbs_pkg::RegRate: rate_q <= cfg.data;
				zcbs_pkg::RegMinPer: min_q <= cfg.data;
				zcbs_pkg::RegMaxPer: max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	zcbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_last(in.last_sample), .in_ready(in.ready),
		.out_busy(ovalid_q), .sts(sts), .cmd(cmd)
	);

	zcbs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .sample(in.sample),
		.rate_q8(rate_q), .min_q8(min_q), .max_q8(max_q),
		.mean_q8(mean), .spread_q8(spread), .db_q8(db), .has_per(hp), .breath(br)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.load_out) ovalid_q <= 1'b1;
		else if (out.ready) ovalid_q <= 1'b0;
	end

	assign out.valid = ovalid_q;
	assign out.mean_period_q8 = mean;
	assign out.period_spread_q8 = spread;
	assign out.energy_db_q8 = db;
	assign out.has_period = hp;
	assign out.is_breathing = br;

endmodule

### tb/sv/tb.sv
module tb;

	typedef struct {
		logic [15:0] mean;
		logic [15:0] spread;
		logic signed [15:0] db;
		logic has;
		logic brth;
	} breath_res_t;

	typedef struct {
		logic signed [15:0] smp;
		bit last;
		bit typed;
		breath_res_t res;
	} stim_row_t;

	localparam int WatchLimit = 5000;

	logic clk = 1'b0;
	logic arst_n;

	zcbs_in_if in_ch();
	zcbs_out_if out_ch();
	zcbs_cfg_if cfg_ch();

	zero_crossing_breath_stats u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source),
		.cfg(cfg_ch.sink)
	);

	always #4 clk = ~clk;

	// predictor copy of registers and window state
	longint unsigned rate_reg, min_reg, max_reg;
	int unsigned win_pos, rise_at, fall_at;
	bit was_neg, have_prev, rise_ok, fall_ok;
	longint unsigned ivl_cnt, ivl_sum, ivl_sq, energy_acc;

	breath_res_t stats_due[$];
	int errors = 0;
	int n_windows = 0, n_breathing = 0, n_samples = 0;
	bit calm = 1'b0;
	int quiet_cycles = 0;

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] energy_to_db(longint unsigned e);
		int p;
		longint unsigned m, l, db;
		if (e == 0) return 16'h8000;
		p = 63;
		while (e[p] == 1'b0) p--;
		m = (p >= 31) ? (e >> (p - 31)) : (e << (31 - p));
		l = longint'(p) << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				l |= 64'd1 << i;
				m >>= 1;
			end
		end
		db = (l * longint'(zcbs_pkg::DbPerLog2Q30) + (64'd1 << 37)) >> 38;
		if (db > 32767) db = 32767;
		return db[15:0];
	endfunction

	function automatic void clear_window();
		win_pos = 0; rise_at = 0; fall_at = 0;
		was_neg = 0; have_prev = 0; rise_ok = 0; fall_ok = 0;
		ivl_cnt = 0; ivl_sum = 0; ivl_sq = 0; energy_acc = 0;
	endfunction

	function automatic void add_interval(longint unsigned d);
		ivl_cnt++;
		ivl_sum += d;
		ivl_sq += d * d;
	endfunction

	// advance window state by one sample; true when a result is due
	function automatic bit breath_step(input logic signed [15:0] smp, input bit last,
			output breath_res_t r);
		bit neg;
		longint signed v;
		longint unsigned n, s, rt, d, num, mean, spread;
		neg = smp < 0;
		v = smp;
		if (win_pos < zcbs_pkg::MaxSamples) begin
			if (have_prev) begin
				if (was_neg && !neg) begin
					if (rise_ok) add_interval(win_pos - rise_at);
					rise_at = win_pos;
					rise_ok = 1;
				end
				if (!was_neg && neg) begin
					if (fall_ok) add_interval(win_pos - fall_at);
					fall_at = win_pos;
					fall_ok = 1;
				end
			end
			energy_acc += longint'(v * v);
			was_neg = neg;
			have_prev = 1;
			win_pos++;
		end
		if (!last) return 0;
		n = ivl_cnt;
		s = ivl_sum;
		rt = (rate_reg == 0) ? 1 : rate_reg;
		r.mean = 0; r.spread = 0; r.brth = 0;
		if (n != 0) begin
			d = n * rt;
			mean = ((s << 17) + d) / (2 * d);
			if (mean > 65535) mean = 65535;
			num = n * ivl_sq - s * s;
			spread = (isqrt(num << 12) * 2048 + d) / (2 * d);
			if (spread > 65535) spread = 65535;
			r.mean = mean[15:0];
			r.spread = spread[15:0];
			r.brth = ((s << 16) >= min_reg * d) && ((s << 16) <= max_reg * d)
				&& (4 * num <= s * s);
		end
		r.db = energy_to_db(energy_acc);
		r.has = (n != 0);
		clear_window();
		return 1;
	endfunction

	// transfer one sample, with optional idle burst ahead of it
	task automatic feed(input logic signed [15:0] smp, input bit last,
			input bit typed = 0, input breath_res_t typed_res = '{default: 0});
		breath_res_t r;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= smp;
		in_ch.last_sample <= last;
		do @(posedge clk); while (!in_ch.ready);
		n_samples++;
		if (breath_step(smp, last, r)) begin
			stats_due = {stats_due, (typed ? typed_res : r)};
			n_windows++;
			if (r.brth) n_breathing++;
		end
		@(negedge clk);
	endtask

	// drop valid and wait for the window-end sequencer to drain
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (stats_due.size() != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			zcbs_pkg::RegRate: rate_reg = val;
			zcbs_pkg::RegMinPer: min_reg = val;
			zcbs_pkg::RegMaxPer: max_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// one window: square-ish wave with random half period, some noise
	task automatic breath_window(input int len, input int half);
		logic signed [15:0] smp;
		bit neg;
		int run;
		neg = 1'($urandom_range(0, 1));
		run = $urandom_range(1, half);
		for (int i = 0; i < len; i++) begin
			if (run == 0) begin
				neg = !neg;
				run = half + int'($urandom_range(0, 2)) - 1;
				if (run < 1) run = 1;
			end
			run--;
			if ($urandom_range(0, 30) == 0)
				smp = 16'($urandom);
			else if (neg)
				smp = 16'(-$signed({1'b0, 16'($urandom_range(1, 32768))}));
			else
				smp = 16'($urandom_range(0, 32767));
			feed(smp, i == len - 1);
		end
	endtask

	// result check
	always @(posedge clk) begin
		breath_res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (stats_due.size() == 0) begin
				$display("%0t: unexpected result mean=%0d spread=%0d db=%0d", $time,
					out_ch.mean_period_q8, out_ch.period_spread_q8, out_ch.energy_db_q8);
				errors++;
			end else begin
				e = stats_due.pop_front();
				if (out_ch.mean_period_q8 !== e.mean) begin
					$display("%0t: mean_period_q8 expected %0d got %0d", $time, e.mean,
						out_ch.mean_period_q8);
					errors++;
				end
				if (out_ch.period_spread_q8 !== e.spread) begin
					$display("%0t: period_spread_q8 expected %0d got %0d", $time,
						e.spread, out_ch.period_spread_q8);
					errors++;
				end
				if (out_ch.energy_db_q8 !== e.db) begin
					$display("%0t: energy_db_q8 expected %0d got %0d", $time, e.db,
						out_ch.energy_db_q8);
					errors++;
				end
				if (out_ch.has_period !== e.has) begin
					$display("%0t: has_period expected %0b got %0b", $time, e.has,
						out_ch.has_period);
					errors++;
				end
				if (out_ch.is_breathing !== e.brth) begin
					$display("%0t: is_breathing expected %0b got %0b", $time, e.brth,
						out_ch.is_breathing);
					errors++;
				end
			end
		end
	end

	// result sink stalls in bursts
	int stall_left = 0;
	always @(negedge clk) begin
		if (calm) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t rows[$];
		breath_res_t silent;
		int len;
		silent = '{mean: 0, spread: 0, db: 16'sh8000, has: 0, brth: 0};
		// zero energy, extremes, short crossing trains
		rows = '{
			'{16'sd0, 1, 1, silent},
			'{-16'sd32768, 1, 0, silent},
			'{16'sd32767, 1, 0, silent},
			'{16'sd0, 0, 0, silent}, '{16'sd0, 0, 0, silent}, '{16'sd0, 1, 1, silent},
			'{-16'sd1, 0, 0, silent}, '{16'sd0, 0, 0, silent}, '{-16'sd1, 0, 0, silent},
			'{16'sd0, 0, 0, silent}, '{-16'sd1, 0, 0, silent}, '{16'sd0, 1, 0, silent},
			'{16'sd32767, 0, 0, silent}, '{-16'sd32768, 0, 0, silent},
			'{-16'sd32768, 0, 0, silent}, '{16'sd32767, 0, 0, silent},
			'{16'sd32767, 0, 0, silent}, '{-16'sd32768, 0, 0, silent},
			'{-16'sd32768, 0, 0, silent}, '{16'sd1, 1, 0, silent}
		};
		in_ch.valid = 0; in_ch.sample = 0; in_ch.last_sample = 0;
		cfg_ch.valid = 0; cfg_ch.index = zcbs_pkg::RegRate; cfg_ch.data = 0;
		out_ch.ready = 0;
		rate_reg = 5120; min_reg = 256; max_reg = 1536;
		clear_window();
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) feed(rows[i].smp, rows[i].last, rows[i].typed, rows[i].res);
		settle();

		// register settings: extremes first, then random ones, then the defaults
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_reg(zcbs_pkg::RegRate, 16'd0);
					write_reg(zcbs_pkg::RegMinPer, 16'd0);
					write_reg(zcbs_pkg::RegMaxPer, 16'hffff); end
				1: begin write_reg(zcbs_pkg::RegRate, 16'hffff);
					write_reg(zcbs_pkg::RegMinPer, 16'hffff);
					write_reg(zcbs_pkg::RegMaxPer, 16'd0); end
				2: begin write_reg(zcbs_pkg::RegRate, 16'd256);
					write_reg(zcbs_pkg::RegMinPer, 16'd0);
					write_reg(zcbs_pkg::RegMaxPer, 16'hffff); end
				7: begin write_reg(zcbs_pkg::RegRate, 16'd5120);
					write_reg(zcbs_pkg::RegMinPer, 16'd256);
					write_reg(zcbs_pkg::RegMaxPer, 16'd1536); calm = 1; end
				default: begin
					write_reg(zcbs_pkg::RegRate, 16'($urandom_range(1024, 12800)));
					write_reg(zcbs_pkg::RegMinPer, 16'($urandom_range(0, 768)));
					write_reg(zcbs_pkg::RegMaxPer, 16'($urandom_range(512, 4096)));
				end
			endcase
			for (int w = 0; w < 6; w++) begin
				len = $urandom_range(2, 32);
				breath_window(len, $urandom_range(1, len > 2 ? len / 2 : 1));
			end
			settle();
		end

		$display("Run covered %0d samples in %0d windows, %0d judged breathing.",
			n_samples, n_windows, n_breathing);
		$display("Settings included zero and full-scale rate and inverted thresholds.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
